### rtl/core/rmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 package
// Beat types, round tables and the round function for the hash core.
// ----------------------------------------------------------------------------
package rmd_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } state_e;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned LenPos = 56;

  function automatic logic [3:0] sel_l(input logic [6:0] i);
    logic [319:0] t;
    t = {4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
         4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
         4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
         4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
         4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
    return t[(7'd79 - i) * 4 +: 4];
  endfunction

  function automatic logic [3:0] sel_r(input logic [6:0] i);
    logic [319:0] t;
    t = {4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
         4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
         4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
         4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
         4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
    return t[(7'd79 - i) * 4 +: 4];
  endfunction

  function automatic logic [3:0] rot_l(input logic [6:0] i);
    logic [319:0] t;
    t = {4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
         4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
         4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
         4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
         4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};
    return t[(7'd79 - i) * 4 +: 4];
  endfunction

  function automatic logic [3:0] rot_r(input logic [6:0] i);
    logic [319:0] t;
    t = {4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
         4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
         4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
         4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
         4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};
    return t[(7'd79 - i) * 4 +: 4];
  endfunction

  function automatic logic [31:0] k_l(input logic [2:0] r);
    logic [31:0] k;
    unique case (r)
      3'd0: k = 32'h00000000;
      3'd1: k = 32'h5a827999;
      3'd2: k = 32'h6ed9eba1;
      3'd3: k = 32'h8f1bbcdc;
      default: k = 32'ha953fd4e;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] k_r(input logic [2:0] r);
    logic [31:0] k;
    unique case (r)
      3'd0: k = 32'h50a28be6;
      3'd1: k = 32'h5c4dd124;
      3'd2: k = 32'h6d703ef3;
      3'd3: k = 32'h7a6d76e9;
      default: k = 32'h00000000;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] boolfn(input logic [2:0] f, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    logic [31:0] v;
    unique case (f)
      3'd0: v = x ^ y ^ z;
      3'd1: v = (x & y) | (~x & z);
      3'd2: v = (x | ~y) ^ z;
      3'd3: v = (x & z) | (y & ~z);
      default: v = x ^ (y | ~z);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

### rtl/core/rmd_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 round unit
// One round of both lines; the shared step reused for all 80 rounds.
// ----------------------------------------------------------------------------
module rmd_round (
  input  logic [6:0]   rnd_i,
  input  logic [31:0]  wl_i,
  input  logic [31:0]  wr_i,
  input  logic [159:0] l_i,
  input  logic [159:0] r_i,
  output logic [159:0] l_o,
  output logic [159:0] r_o
);
  logic [2:0]  grp;
  logic [31:0] la, lb, lc, ld, le, ra, rb, rc, rd, re, tl, tr;

  assign grp = 3'(rnd_i >> 4);
  assign {la, lb, lc, ld, le} = l_i;
  assign {ra, rb, rc, rd, re} = r_i;

  always_comb begin
    tl = la + rmd_pkg::boolfn(grp, lb, lc, ld) + wl_i + rmd_pkg::k_l(grp);
    tl = rmd_pkg::rotl(tl, rmd_pkg::rot_l(rnd_i)) + le;
    tr = ra + rmd_pkg::boolfn(3'd4 - grp, rb, rc, rd) + wr_i + rmd_pkg::k_r(grp);
    tr = rmd_pkg::rotl(tr, rmd_pkg::rot_r(rnd_i)) + re;
  end

  // Shift the line: A<=E, B<=T, C<=B, D<=rol10(C), E<=D.
  assign l_o = {le, tl, lb, rmd_pkg::rotl(lc, 4'd10), ld};
  assign r_o = {re, tr, rb, rmd_pkg::rotl(rc, 4'd10), rd};
endmodule

### rtl/core/ripemd160_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 hash core
// Byte-serial message input, five-word digest output per message.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    rmd_pkg::in_beat_t
// out      out  out_valid_o / out_stall_i  rmd_pkg::out_beat_t
//
// Each accepted data byte is written to the block store; the 64th byte of a
// block starts a compression (load, 80 rounds on the shared round unit, chaining
// update). End of message: each padding block is written one byte a cycle from
// the fill position up to byte 63 and then compressed; a marker at byte 56 or
// later needs a second block. Five digest beats follow, one a cycle unless the
// output stalls; in_stall_o stays high meanwhile.
// Reset sets the chaining words to the initial vector and clears the counts.
// Output stall holds the current digest beat; the sequencer waits on it.
// ----------------------------------------------------------------------------
module ripemd160_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmd_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmd_pkg::out_beat_t  out_data_o
);
  rmd_pkg::state_e state_q, state_d;

  logic [159:0] chain_q, chain_d;
  logic [159:0] l_q, r_q, l_nx, r_nx;
  logic [6:0]   rnd_q, rnd_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;
  logic         fin_q, fin_d;     // end of message pending
  logic         mark_q, mark_d;   // pad marker still to be written
  logic         lenb_q, lenb_d;   // padding block carries the length
  logic [2:0]   widx_q, widx_d;
  logic         acc;

  // Block store: sixteen little-endian words, written a byte at a time.
  logic [3:0][7:0] mem [16];
  logic         wr_en;
  logic [5:0]   wr_addr;
  logic [7:0]   wr_data;
  logic [31:0]  wl_q, wr_q;
  logic [3:0]   rl_a, rr_a;
  logic [6:0]   rnd_rd;

  assign acc = in_valid_i && !in_stall_o;

  // Fetch words one round ahead so read data is registered.
  assign rnd_rd = (state_q == rmd_pkg::ST_LOAD) ? 7'd0 : rnd_q + 7'd1;
  assign rl_a = rmd_pkg::sel_l(rnd_rd);
  assign rr_a = rmd_pkg::sel_r(rnd_rd);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_data;
    end
    wl_q <= mem[rl_a];
    wr_q <= mem[rr_a];
  end

  rmd_round u_round (
    .rnd_i (rnd_q),
    .wl_i  (wl_q),
    .wr_i  (wr_q),
    .l_i   (l_q),
    .r_i   (r_q),
    .l_o   (l_nx),
    .r_o   (r_nx)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmd_pkg::ST_COLLECT: begin
        if (acc) begin
          if (in_data_i.has_byte && fill_q == 6'd63) state_d = rmd_pkg::ST_LOAD;
          else if (in_data_i.end_of_message) state_d = rmd_pkg::ST_PAD;
        end
      end
      rmd_pkg::ST_LOAD:   state_d = rmd_pkg::ST_ROUND;
      rmd_pkg::ST_ROUND:  if (rnd_q == 7'd79) state_d = rmd_pkg::ST_UPDATE;
      rmd_pkg::ST_UPDATE: begin
        if (!fin_q) state_d = rmd_pkg::ST_COLLECT;
        else if (lenb_q) state_d = rmd_pkg::ST_EMIT;
        else state_d = rmd_pkg::ST_PAD;
      end
      rmd_pkg::ST_PAD:    if (fill_q == 6'd63) state_d = rmd_pkg::ST_LOAD;
      rmd_pkg::ST_EMIT:   if (!out_stall_i && widx_q == 3'd4) state_d = rmd_pkg::ST_COLLECT;
      default:            state_d = rmd_pkg::ST_COLLECT;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    chain_d = chain_q;
    rnd_d   = rnd_q;
    fill_d  = fill_q;
    len_d   = len_q;
    fin_d   = fin_q;
    mark_d  = mark_q;
    lenb_d  = lenb_q;
    widx_d  = widx_q;
    wr_en   = 1'b0;
    wr_addr = fill_q;
    wr_data = in_data_i.msg_byte;
    unique case (state_q)
      rmd_pkg::ST_COLLECT: begin
        if (acc) begin
          fin_d  = in_data_i.end_of_message;
          mark_d = in_data_i.end_of_message;
          lenb_d = 1'b0;
          if (in_data_i.has_byte) begin
            wr_en  = 1'b1;
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 64'd8;
          end
        end
      end
      rmd_pkg::ST_PAD: begin
        // Marker first, then zeros, then the length in the last eight bytes.
        wr_en = 1'b1;
        if (mark_q) begin
          wr_data = rmd_pkg::PadByte;
          mark_d  = 1'b0;
          // Marker past the length slot: the next block takes the length.
          lenb_d  = (fill_q < 6'(rmd_pkg::LenPos));
        end else if (lenb_q && fill_q >= 6'(rmd_pkg::LenPos)) begin
          wr_data = 8'(len_q >> {fill_q[2:0], 3'b000});
        end else begin
          wr_data = 8'h00;
        end
        fill_d = fill_q + 6'd1;
      end
      rmd_pkg::ST_LOAD:  rnd_d = 7'd0;
      rmd_pkg::ST_ROUND: rnd_d = rnd_q + 7'd1;
      rmd_pkg::ST_UPDATE: begin
        chain_d = {chain_q[127:96] + l_q[95:64]  + r_q[63:32],
                   chain_q[95:64]  + l_q[63:32]  + r_q[31:0],
                   chain_q[63:32]  + l_q[31:0]   + r_q[159:128],
                   chain_q[31:0]   + l_q[159:128] + r_q[127:96],
                   chain_q[159:128] + l_q[127:96] + r_q[95:64]};
        widx_d = 3'd0;
        if (fin_q && !lenb_q && !mark_q) lenb_d = 1'b1;
      end
      rmd_pkg::ST_EMIT: begin
        if (!out_stall_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd4) begin
            chain_d = {rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3, rmd_pkg::IV4};
            len_d   = 64'd0;
            fin_d   = 1'b0;
            lenb_d  = 1'b0;
            fill_d  = 6'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rmd_pkg::ST_COLLECT;
      chain_q  <= {rmd_pkg::IV0, rmd_pkg::IV1, rmd_pkg::IV2, rmd_pkg::IV3, rmd_pkg::IV4};
      rnd_q    <= 7'd0;
      fill_q   <= 6'd0;
      len_q    <= 64'd0;
      fin_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenb_q   <= 1'b0;
      widx_q   <= 3'd0;
    end else begin
      state_q  <= state_d;
      chain_q  <= chain_d;
      rnd_q    <= rnd_d;
      fill_q   <= fill_d;
      len_q    <= len_d;
      fin_q    <= fin_d;
      mark_q   <= mark_d;
      lenb_q   <= lenb_d;
      widx_q   <= widx_d;
    end
  end

  // Working lines load from the chaining words, then advance one round a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == rmd_pkg::ST_LOAD) begin
      l_q <= chain_q;
      r_q <= chain_q;
    end else if (state_q == rmd_pkg::ST_ROUND) begin
      l_q <= l_nx;
      r_q <= r_nx;
    end
  end

  assign in_stall_o  = (state_q != rmd_pkg::ST_COLLECT);
  assign out_valid_o = (state_q == rmd_pkg::ST_EMIT);
  assign out_data_o.digest_word = chain_q[(3'd4 - widx_q) * 32 +: 32];
  assign out_data_o.word_index  = widx_q;
  assign out_data_o.last_word   = (widx_q == 3'd4);
endmodule

### verif/tb_ripemd160_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 hash core testbench
// Drives byte beats with random bursts and gaps, stalls the digest channel on
// its own pattern, and checks every digest beat against an in-bench hash.
// ----------------------------------------------------------------------------

class rmd_scoreboard;
  rmd_pkg::out_beat_t digest_q[$];
  logic [31:0] chain[5];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [63:0] bits;
  int unsigned errors;

  function new();
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = rmd_pkg::IV0; chain[1] = rmd_pkg::IV1; chain[2] = rmd_pkg::IV2;
    chain[3] = rmd_pkg::IV3; chain[4] = rmd_pkg::IV4;
    fill = 0;
    bits = '0;
  endfunction

  static function logic [31:0] rl(logic [31:0] x, int n);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  static function logic [31:0] mix(int f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    case (f)
      0: return x ^ y ^ z;
      1: return (x & y) | (~x & z);
      2: return (x | ~y) ^ z;
      3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function void compress_block();
    int sl[80] = '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
      7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8, 3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
      1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2, 4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
    int sr[80] = '{5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
      6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2, 15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
      8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14, 12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
    int ql[80] = '{11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
      7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12, 11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
      11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12, 9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
    int qr[80] = '{8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
      9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11, 9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
      15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8, 8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
    logic [31:0] kl[5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e};
    logic [31:0] kr[5] = '{32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h0};
    logic [31:0] w[16];
    logic [31:0] a[5];
    logic [31:0] b[5];
    logic [31:0] t;
    int r;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain;
    b = chain;
    for (int i = 0; i < 80; i++) begin
      r = i / 16;
      t = rl(a[0] + mix(r, a[1], a[2], a[3]) + w[sl[i]] + kl[r], ql[i]) + a[4];
      a[0] = a[4]; a[4] = a[3]; a[3] = rl(a[2], 10); a[2] = a[1]; a[1] = t;
      t = rl(b[0] + mix(4 - r, b[1], b[2], b[3]) + w[sr[i]] + kr[r], qr[i]) + b[4];
      b[0] = b[4]; b[4] = b[3]; b[3] = rl(b[2], 10); b[2] = b[1]; b[1] = t;
    end
    t        = chain[1] + a[2] + b[3];
    chain[1] = chain[2] + a[3] + b[4];
    chain[2] = chain[3] + a[4] + b[0];
    chain[3] = chain[4] + a[0] + b[1];
    chain[4] = chain[0] + a[1] + b[2];
    chain[0] = t;
  endfunction

  // Note an accepted input beat; an end beat queues five digest words.
  function void note_input(rmd_pkg::in_beat_t b);
    rmd_pkg::out_beat_t o;
    if (b.has_byte) begin
      blk[fill] = b.msg_byte;
      fill++;
      bits += 64'd8;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!b.end_of_message) return;
    blk[fill] = rmd_pkg::PadByte;
    fill++;
    if (fill > rmd_pkg::LenPos) begin
      while (fill < 64) begin blk[fill] = 8'h00; fill++; end
      compress_block();
      fill = 0;
    end
    while (fill < rmd_pkg::LenPos) begin blk[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      o.digest_word = chain[i];
      o.word_index  = 3'(i);
      o.last_word   = (i == 4);
      digest_q.push_back(o);
    end
    restart();
  endfunction

  function void check_output(rmd_pkg::out_beat_t got);
    rmd_pkg::out_beat_t exp;
    if (digest_q.size() == 0) begin
      $error("unexpected digest beat %h", got);
      errors++;
      return;
    end
    exp = digest_q.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $error("digest_word expected %h actual %h", exp.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_index !== exp.word_index) begin
      $error("word_index expected %0d actual %0d", exp.word_index, got.word_index);
      errors++;
    end
    if (got.last_word !== exp.last_word) begin
      $error("last_word expected %0b actual %0b", exp.last_word, got.last_word);
      errors++;
    end
  endfunction
endclass

module tb_ripemd160_hash;

  localparam int unsigned CycleLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  rmd_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  rmd_pkg::out_beat_t out_data_o;

  rmd_scoreboard sb;
  int unsigned   cycles;
  int unsigned   gap_left;   // cycles left in the current sender gap
  int unsigned   burst_left; // beats left before the next gap
  int unsigned   stall_mode; // receiver stall pattern selector

  ripemd160_hash u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Score both channels at the edge; the handshake is sampled before any
  // nonblocking update of this step lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_output(out_data_o);
    end
  end

  // Receiver stall pattern: phases of no stall, light, heavy and bursty stall.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= cycles[4];
    endcase
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one beat: hold through gaps and stalls until it is accepted.
  task automatic send_beat(logic [7:0] d, logic hb, logic eom);
    rmd_pkg::in_beat_t b;
    b.msg_byte = d;
    b.has_byte = hb;
    b.end_of_message = eom;
    while (gap_left > 0) begin
      gap_left--;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) in_valid_i <= 1'b0;
  endtask

  // Send a message of n random bytes; end beat carries the last byte or none.
  task automatic send_message(int unsigned n, bit force_carry);
    bit carry;
    carry = (n > 0) && (force_carry || ($urandom_range(0, 1) == 1));
    for (int unsigned i = 0; i < n - carry; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0); // idle-only beat
      send_beat(8'($urandom), 1'b1, 1'b0);
    end
    if (carry) send_beat(8'($urandom), 1'b1, 1'b1);
    else send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Drop valid unless a gap already did, then wait for every queued digest beat.
  task automatic drain();
    if (gap_left == 0) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.digest_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    stall_mode = 0;
    gap_left = 0;
    burst_left = 4;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, extreme bytes, end beats with and without a byte.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'haa, 1'b1, 1'b0);
    send_beat(8'h55, 1'b1, 1'b1);
    send_beat(8'h80, 1'b1, 1'b1);
    drain();

    // Marker at byte 56 needs a second block; a full block ends on its last byte.
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    drain();

    // Random part: short messages.
    for (int m = 0; m < 3; m++) begin
      send_message($urandom_range(0, 6), 1'b0);
      if (m == 1) drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
